>>> hw/rtl/rne_pkg.sv
// ----------------------------------------------------------------------------
// rne_pkg
// Shared types, constants and numeral tables for the roman numeral encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

  localparam int unsigned ValueW   = 16;
  localparam int unsigned RemW     = 12;
  localparam int unsigned SymbolW  = 8;
  localparam int unsigned NumSyms  = 13;
  localparam int unsigned SymIdxW  = $clog2(NumSyms);
  localparam int unsigned WeightW  = 10;
  localparam logic [ValueW-1:0] LimitValue = ValueW'(4000);

  localparam logic [SymbolW-1:0] ChM    = 8'h4D;
  localparam logic [SymbolW-1:0] ChD    = 8'h44;
  localparam logic [SymbolW-1:0] ChC    = 8'h43;
  localparam logic [SymbolW-1:0] ChL    = 8'h4C;
  localparam logic [SymbolW-1:0] ChX    = 8'h58;
  localparam logic [SymbolW-1:0] ChV    = 8'h56;
  localparam logic [SymbolW-1:0] ChI    = 8'h49;
  localparam logic [SymbolW-1:0] ChNone = 8'h00;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } rne_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic free;  // output stage can take a new item this cycle
    logic fin;   // the item produced on a step now is the final one
  } rne_sts_t;

  // one table entry: weight, first letter, optional second letter
  typedef struct packed {
    logic [WeightW-1:0] weight;
    logic [SymbolW-1:0] first;
    logic [SymbolW-1:0] second;
    logic               pair;
  } rne_sym_t;

  // greedy table, largest weight first
  function automatic rne_sym_t rne_sym(input logic [SymIdxW-1:0] idx);
    rne_sym_t s;
    case (idx)
      4'd0:    s = '{WeightW'(1000), ChM, ChNone, 1'b0};
      4'd1:    s = '{WeightW'(900),  ChC, ChM,    1'b1};
      4'd2:    s = '{WeightW'(500),  ChD, ChNone, 1'b0};
      4'd3:    s = '{WeightW'(400),  ChC, ChD,    1'b1};
      4'd4:    s = '{WeightW'(100),  ChC, ChNone, 1'b0};
      4'd5:    s = '{WeightW'(90),   ChX, ChC,    1'b1};
      4'd6:    s = '{WeightW'(50),   ChL, ChNone, 1'b0};
      4'd7:    s = '{WeightW'(40),   ChX, ChL,    1'b1};
      4'd8:    s = '{WeightW'(10),   ChX, ChNone, 1'b0};
      4'd9:    s = '{WeightW'(9),    ChI, ChX,    1'b1};
      4'd10:   s = '{WeightW'(5),    ChV, ChNone, 1'b0};
      4'd11:   s = '{WeightW'(4),    ChI, ChV,    1'b1};
      4'd12:   s = '{WeightW'(1),    ChI, ChNone, 1'b0};
      default: s = '{WeightW'(1),    ChI, ChNone, 1'b0};
    endcase
    return s;
  endfunction

endpackage

>>> hw/rtl/roman_numeral_encoder.sv
// ----------------------------------------------------------------------------
// roman_numeral_encoder
// Turns a value of 1..3999 into its Roman numeral, one ASCII letter per item.
// ----------------------------------------------------------------------------
// after a load, the first letter enters the output register once the output is free
// throughput: one letter per cycle while the output is free, up to 15 letters
//   per value; a new value is taken only once the last letter of the previous
//   one has entered the output register
// the greedy weight table is searched combinationally for each letter
// reset: synchronous active-low rst_n clears controller and output valid
module roman_numeral_encoder
  import rne_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [ValueW-1:0]  in_tdata,    // [15:0] value
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [SymbolW-1:0] out_tdata,   // [7:0] symbol
  output logic               out_tlast,
  output logic               out_tuser    // [0] invalid
);

  rne_cmd_t cmd;
  rne_sts_t sts;

  rne_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rne_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .value      (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // an invalid item is always a lone letterless final item
  a_invalid_alone : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == ChNone))
    else $error("invalid item not marked last or carries a letter");

  // a taken value keeps the input closed for at least the next cycle
  a_busy_after_load : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input reopened right after a value was taken");

  // every value yields at least one item before the input reopens
  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> ##1 out_tvalid)
    else $error("no item produced after a value was taken");

endmodule

>>> hw/rtl/rne_dp.sv
// ----------------------------------------------------------------------------
// rne_dp
// Datapath: remaining value, pending second letter and output register.
// ----------------------------------------------------------------------------
module rne_dp
  import rne_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  rne_cmd_t           cmd,
  output rne_sts_t           sts,
  input  logic [ValueW-1:0]  value,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [SymbolW-1:0] out_tdata,   // [7:0] symbol
  output logic               out_tlast,
  output logic               out_tuser    // [0] invalid
);

  logic [RemW-1:0]    rem_r, rem_nxt;
  logic               bad_r, bad_nxt;
  logic               pend_r, pend_nxt;
  logic [SymbolW-1:0] pend_ch_r, pend_ch_nxt;
  logic               vld_r, vld_nxt;
  logic [SymbolW-1:0] sym_r, sym_nxt;
  logic               last_r, last_nxt;
  logic               inv_r, inv_nxt;

  logic [SymIdxW-1:0] sel;
  rne_sym_t           cand;
  rne_sym_t           ent;
  logic [RemW-1:0]    rem_sub;
  logic               fin;

  // pick the largest weight that still fits
  always_comb begin
    sel  = SymIdxW'(NumSyms - 1);
    cand = rne_sym(SymIdxW'(NumSyms - 1));
    for (int k = NumSyms - 1; k >= 0; k--) begin
      cand = rne_sym(SymIdxW'(k));
      if (rem_r >= {{(RemW-WeightW){1'b0}}, cand.weight}) begin
        sel = SymIdxW'(k);
      end
    end
  end

  assign ent     = rne_sym(sel);
  assign rem_sub = rem_r - {{(RemW-WeightW){1'b0}}, ent.weight};

  always_comb begin
    if (bad_r) begin
      fin = 1'b1;
    end else if (pend_r) begin
      fin = (rem_r == '0);
    end else begin
      fin = (rem_sub == '0) && !ent.pair;
    end
  end

  assign sts.free = !vld_r || out_tready;
  assign sts.fin  = fin;

  always_comb begin
    rem_nxt     = rem_r;
    bad_nxt     = bad_r;
    pend_nxt    = pend_r;
    pend_ch_nxt = pend_ch_r;
    vld_nxt     = vld_r && !out_tready;
    sym_nxt     = sym_r;
    last_nxt    = last_r;
    inv_nxt     = inv_r;
    if (cmd.load) begin
      rem_nxt  = value[RemW-1:0];
      bad_nxt  = (value == '0) || (value >= LimitValue);
      pend_nxt = 1'b0;
    end else if (cmd.step) begin
      vld_nxt  = 1'b1;
      last_nxt = fin;
      if (bad_r) begin
        sym_nxt = ChNone;
        inv_nxt = 1'b1;
      end else if (pend_r) begin
        sym_nxt  = pend_ch_r;
        inv_nxt  = 1'b0;
        pend_nxt = 1'b0;
      end else begin
        sym_nxt     = ent.first;
        inv_nxt     = 1'b0;
        rem_nxt     = rem_sub;
        pend_nxt    = ent.pair;
        pend_ch_nxt = ent.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      bad_r  <= 1'b0;
      pend_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      rem_r  <= rem_nxt;
      bad_r  <= bad_nxt;
      pend_r <= pend_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_ch_r <= pend_ch_nxt;
    sym_r     <= sym_nxt;
    last_r    <= last_nxt;
    inv_r     <= inv_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = sym_r;
  assign out_tlast  = last_r;
  assign out_tuser  = inv_r;

endmodule

>>> hw/rtl/rne_ctrl.sv
// ----------------------------------------------------------------------------
// rne_ctrl
// Controller: takes a value, then steps out one letter per free output slot.
// ----------------------------------------------------------------------------
module rne_ctrl
  import rne_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output rne_cmd_t cmd,
  input  rne_sts_t sts
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.free) begin
          cmd.step = 1'b1;
          if (sts.fin) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
